/* rtl/hbkrd_pkg.sv */
// Package for the HID boot keyboard report differ.
// Holds report geometry, event count and the event kind codes.
// No dependencies.
package hbkrd_pkg;

  localparam int SLOT_COUNT      = 6;
  localparam int MOD_BITS        = 8;
  localparam int USAGE_W         = 8;
  localparam int FIRST_KEY_USAGE = 4;
  localparam int EVENT_COUNT     = MOD_BITS + 2 * SLOT_COUNT;

  localparam int REL_BASE   = MOD_BITS;
  localparam int PRESS_BASE = MOD_BITS + SLOT_COUNT;

  typedef enum logic [1:0] {
    KIND_MOD_PRESS   = 2'd0,
    KIND_MOD_RELEASE = 2'd1,
    KIND_KEY_PRESS   = 2'd2,
    KIND_KEY_RELEASE = 2'd3
  } event_kind_t;

  typedef logic [USAGE_W-1:0] usage_t;

endpackage

/* rtl/hid_boot_keyboard_report_diff.sv */
// HID boot keyboard report differ: turns each ok report into press and release events.
// The first event of a report goes through the event buffer, then the output register.
// Throughput: one event per cycle unless the output stalls; at most 20 events per report.
// A report is taken while no events are buffered or in the cycle the last one moves to output.
// Reset (rst, synchronous): stored report cleared to zero, event buffer and output emptied.
// Depends on hbkrd_pkg.
module hid_boot_keyboard_report_diff (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // modifier_bits, key_slot_0 .. key_slot_5
  input  logic [0:0]  s_tuser,  // report_ok
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // event_code
  output logic [2:0]  m_tuser,  // event_kind, report_rejected
  output logic        m_tlast   // last_event
);

  localparam int NS = hbkrd_pkg::SLOT_COUNT;
  localparam int NM = hbkrd_pkg::MOD_BITS;
  localparam int NE = hbkrd_pkg::EVENT_COUNT;

  logic [NM-1:0]       prev_mods;
  hbkrd_pkg::usage_t   prev_slots [NS];

  logic [NE-1:0]       buf_mask;
  logic [NM-1:0]       buf_mods;
  hbkrd_pkg::usage_t   buf_old [NS];
  hbkrd_pkg::usage_t   buf_new [NS];
  logic                buf_rej;

  hbkrd_pkg::usage_t   out_code;
  hbkrd_pkg::event_kind_t out_kind;
  logic                out_rej;
  logic                out_last;

  logic [NM-1:0]       in_mods;
  hbkrd_pkg::usage_t   in_slots [NS];
  logic [NS-1:0]       rel_hit;
  logic [NS-1:0]       press_hit;
  logic                in_rej;
  logic [NE-1:0]       in_mask;

  logic                accept;
  logic                move;
  logic [NE-1:0]       pick;
  logic [NE-1:0]       rest;
  hbkrd_pkg::usage_t   sel_code;
  hbkrd_pkg::event_kind_t sel_kind;
  hbkrd_pkg::usage_t   evt_code [NE];
  hbkrd_pkg::event_kind_t evt_kind [NE];

  // Compare the incoming report with the stored one
  always_comb begin
    logic old_found;
    logic new_found;
    in_mods = s_tdata[NM-1:0];
    for (int i = 0; i < NS; i++) begin
      in_slots[i] = s_tdata[NM + hbkrd_pkg::USAGE_W * i +: hbkrd_pkg::USAGE_W];
    end
    in_rej = 1'b0;
    for (int i = 0; i < NS; i++) begin
      old_found = 1'b0;
      new_found = 1'b0;
      for (int j = 0; j < NS; j++) begin
        if (in_slots[j] == prev_slots[i]) old_found = 1'b1;
        if (prev_slots[j] == in_slots[i]) new_found = 1'b1;
      end
      rel_hit[i]   = (prev_slots[i] != '0) && !old_found;
      press_hit[i] = (in_slots[i] >= hbkrd_pkg::USAGE_W'(hbkrd_pkg::FIRST_KEY_USAGE))
                     && !new_found;
      if ((in_slots[i] != '0) &&
          (in_slots[i] < hbkrd_pkg::USAGE_W'(hbkrd_pkg::FIRST_KEY_USAGE))) begin
        in_rej = 1'b1;
      end
    end
    in_mask = s_tuser[0] ? {press_hit, rel_hit, in_mods ^ prev_mods} : '0;
  end

  // Per-event code and kind from the buffered report
  always_comb begin
    for (int e = 0; e < NM; e++) begin
      evt_code[e] = hbkrd_pkg::USAGE_W'(e);
      evt_kind[e] = buf_mods[e] ? hbkrd_pkg::KIND_MOD_PRESS : hbkrd_pkg::KIND_MOD_RELEASE;
    end
    for (int i = 0; i < NS; i++) begin
      evt_code[hbkrd_pkg::REL_BASE + i]   = buf_old[i];
      evt_kind[hbkrd_pkg::REL_BASE + i]   = hbkrd_pkg::KIND_KEY_RELEASE;
      evt_code[hbkrd_pkg::PRESS_BASE + i] = buf_new[i];
      evt_kind[hbkrd_pkg::PRESS_BASE + i] = hbkrd_pkg::KIND_KEY_PRESS;
    end
  end

  // Pick the lowest pending event
  always_comb begin
    pick     = buf_mask & (~buf_mask + NE'(1));
    rest     = buf_mask & ~pick;
    sel_code = '0;
    sel_kind = hbkrd_pkg::KIND_MOD_PRESS;
    for (int e = 0; e < NE; e++) begin
      if (pick[e]) begin
        sel_code = evt_code[e];
        sel_kind = evt_kind[e];
      end
    end
  end

  assign move     = (buf_mask != '0) && (!m_tvalid || m_tready);
  assign s_tready = (buf_mask == '0) || (move && (rest == '0));
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods <= '0;
      for (int i = 0; i < NS; i++) prev_slots[i] <= '0;
      buf_mask  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept && s_tuser[0] && !in_rej) begin
        prev_mods <= in_mods;
        for (int i = 0; i < NS; i++) prev_slots[i] <= in_slots[i];
      end
      if (accept) begin
        buf_mask <= in_mask;
      end else if (move) begin
        buf_mask <= rest;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_mods <= in_mods;
      buf_rej  <= in_rej;
      for (int i = 0; i < NS; i++) begin
        buf_old[i] <= prev_slots[i];
        buf_new[i] <= in_slots[i];
      end
    end
    if (move) begin
      out_code <= sel_code;
      out_kind <= sel_kind;
      out_rej  <= buf_rej;
      out_last <= (rest == '0);
    end
  end

  assign m_tdata = out_code;
  assign m_tuser = {out_rej, out_kind};
  assign m_tlast = out_last;

endmodule

/* rtl/hbkrd_checker.sv */
// Port-level checks for the HID boot keyboard report differ, and the bind that attaches them.
// Depends on hbkrd_pkg and hid_boot_keyboard_report_diff.
module hbkrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled transaction changed");

  a_mod_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser[1:0] == hbkrd_pkg::KIND_MOD_PRESS) ||
                 (m_tuser[1:0] == hbkrd_pkg::KIND_MOD_RELEASE))
    |-> m_tdata < 8'(hbkrd_pkg::MOD_BITS))
    else $error("modifier event with bad index");

  a_press_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == hbkrd_pkg::KIND_KEY_PRESS)
    |-> m_tdata >= 8'(hbkrd_pkg::FIRST_KEY_USAGE))
    else $error("key press below first key usage");

endmodule

bind hid_boot_keyboard_report_diff hbkrd_checker u_checker (.*);
